@@ hdl/alpha_precompose_with_mask_assert.svh @@
// Assertion macros shared by the checkers of this block.
// Each macro samples on the rising edge of clk and is switched off while arst_n is low.
`ifndef ALPHA_PRECOMPOSE_WITH_MASK_ASSERT_SVH
`define ALPHA_PRECOMPOSE_WITH_MASK_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define APWM_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define APWM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/apwm_pkg.sv @@
package apwm_pkg;

	// Frame geometry.
	localparam int MAX_SIDE = 256;
	localparam int SIDE_W   = 9;
	localparam int CNT_W    = 8;
	localparam int WORDS_W  = 5;
	localparam int OFFSET_W = 13;
	localparam int BITPOS_W = 3;
	localparam int CHAN_W   = 8;
	localparam int COLOUR_W = 3 * CHAN_W;

	// Stream and register port widths.
	localparam int S_TDATA_W  = 32;
	localparam int M_TDATA_W  = 40;
	localparam int M_TUSER_W  = 1;
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W  = 2;

	// Register indexes, taken from paddr[3:2].
	localparam logic [REG_IDX_W-1:0] REG_BACKGROUND = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_WIDTH      = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_HEIGHT     = 2'd2;

	localparam logic [SIDE_W-1:0] SIDE_RESET   = 9'd16;
	localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'd255;
	localparam logic [CHAN_W-1:0] ALPHA_CLEAR  = 8'd0;
	localparam logic [CHAN_W-1:0] ROUND_BIAS   = 8'd127;

	// Pixel held in the input register together with its mask position.
	typedef struct packed {
		logic [CHAN_W-1:0]  blue;
		logic [CHAN_W-1:0]  green;
		logic [CHAN_W-1:0]  red;
		logic [CHAN_W-1:0]  alpha;
		logic [CNT_W-1:0]   col;
		logic [CNT_W-1:0]   rev_row;
		logic [WORDS_W-1:0] words;
		logic               last;
	} pixel_s1_t;

	// Last valid index of a side, with 0 read as 1 and large values saturated.
	function automatic logic [CNT_W-1:0] side_last(input logic [SIDE_W-1:0] side);
		if (side == '0)
			return '0;
		else if (side > SIDE_W'(MAX_SIDE))
			return '1;
		else
			return CNT_W'(side - 1'b1);
	endfunction

	// Rounded blend of one channel; the divide by 255 is done as
	// (x + 1 + (x >> 8)) >> 8, which is exact for every x below 65535 and so
	// for every sum a blend can produce.
	function automatic logic [CHAN_W-1:0] blend(
		input logic [CHAN_W-1:0] src,
		input logic [CHAN_W-1:0] alpha,
		input logic [CHAN_W-1:0] bg
	);
		logic [15:0] sum;
		logic [16:0] quot;
		sum = {8'd0, src} * {8'd0, alpha}
			+ {8'd0, bg} * {8'd0, ALPHA_OPAQUE - alpha}
			+ {8'd0, ROUND_BIAS};
		quot = {1'b0, sum} + 17'd1 + {9'd0, sum[15:8]};
		return quot[15:8];
	endfunction

endpackage

@@ hdl/alpha_precompose_with_mask.sv @@
// Composites a raster stream of BGRA pixels over a solid background colour.
// Input transfer on s_*: s_tdata holds blue, green, red and alpha, one byte each,
// from the lowest byte up, top row first and left to right.
// Output transfer on m_*: the blended colour, the byte offset and MSB-first bit
// position of the pixel in a bottom-up 1-bpp mask with rows padded to 16-bit
// words, a transparency flag on m_tuser and the frame's last pixel on m_tlast.
// A pixel with zero alpha comes out black with the transparency flag set.
// The APB port holds the background colour and the frame width and height;
// writing a size restarts the frame at its first pixel.
// The pixel passes one input register and one output register, with the blend and
// the offset multiply in between; m_tvalid rises when the output register takes it.
// Throughput is one pixel per clock while m_tready is high; s_tready stays high
// while the input register is empty or the output register is empty or being
// taken, so a held-low m_tready stalls the input after two pixels at most, and
// nothing is lost or repeated.
// Reset empties both registers, sets the background to black, the frame to
// 16 by 16 pixels and the column and row counters to zero.
module alpha_precompose_with_mask
	import apwm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// Register port.
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	// Source pixels.
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,   // blue, green, red, alpha
	// Composited pixels.
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_TDATA_W-1:0]  m_tdata,   // blue, green, red, mask_offset, mask_bit_pos
	output logic [M_TUSER_W-1:0]  m_tuser,   // transparent
	output logic                  m_tlast    // last_pixel
);

	logic [COLOUR_W-1:0]  bg_q;
	logic [SIDE_W-1:0]    width_q;
	logic [SIDE_W-1:0]    height_q;
	logic [CNT_W-1:0]     col_q;
	logic [CNT_W-1:0]     row_q;

	logic [REG_IDX_W-1:0] reg_idx;
	logic                 cfg_wr;
	logic                 in_xfer;
	logic                 adv_s2;

	logic [CNT_W-1:0]     w_last;
	logic [CNT_W-1:0]     h_last;
	logic [CNT_W-1:0]     col_cur;
	logic [CNT_W-1:0]     row_cur;
	logic                 end_row;
	logic                 end_frame;

	logic                 valid_s1;
	pixel_s1_t            pix_s1;
	logic                 valid_s2;
	logic [M_TDATA_W-1:0] data_s2;
	logic                 transp_s2;
	logic                 last_s2;

	logic                 transp;
	logic [COLOUR_W-1:0]  colour;
	logic [12:0]          row_base;
	logic [OFFSET_W-1:0]  offset;

	// Register port decode; every access completes in its access cycle.
	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		unique case (reg_idx)
			REG_BACKGROUND: prdata = APB_DATA_W'(bg_q);
			REG_WIDTH:      prdata = APB_DATA_W'(width_q);
			REG_HEIGHT:     prdata = APB_DATA_W'(height_q);
			default:        prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bg_q     <= '0;
			width_q  <= SIDE_RESET;
			height_q <= SIDE_RESET;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_BACKGROUND: bg_q     <= pwdata[COLOUR_W-1:0];
				REG_WIDTH:      width_q  <= pwdata[SIDE_W-1:0];
				REG_HEIGHT:     height_q <= pwdata[SIDE_W-1:0];
				default:        ;
			endcase
		end
	end

	// Handshake: the output register is refilled whenever it is empty or taken.
	assign adv_s2   = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || adv_s2;
	assign in_xfer  = s_tvalid && s_tready;

	// Position of the incoming pixel, held inside the current frame size.
	assign w_last    = side_last(width_q);
	assign h_last    = side_last(height_q);
	assign col_cur   = (col_q > w_last) ? w_last : col_q;
	assign row_cur   = (row_q > h_last) ? h_last : row_q;
	assign end_row   = (col_cur == w_last);
	assign end_frame = end_row && (row_cur == h_last);

	// Column and row counters; a size write starts a new frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_wr && (reg_idx == REG_WIDTH || reg_idx == REG_HEIGHT)) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_xfer) begin
			if (end_row) begin
				col_q <= '0;
				row_q <= end_frame ? '0 : row_cur + 1'b1;
			end else begin
				col_q <= col_cur + 1'b1;
				row_q <= row_cur;
			end
		end
	end

	// Input register: the pixel, its column, its row counted from the bottom
	// and the mask stride in 16-bit words.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			pix_s1.blue    <= s_tdata[7:0];
			pix_s1.green   <= s_tdata[15:8];
			pix_s1.red     <= s_tdata[23:16];
			pix_s1.alpha   <= s_tdata[31:24];
			pix_s1.col     <= col_cur;
			pix_s1.rev_row <= h_last - row_cur;
			pix_s1.words   <= {1'b0, w_last[7:4]} + 1'b1;
			pix_s1.last    <= end_frame;
		end
	end

	// Blend each channel, or black out a fully transparent pixel.
	assign transp = (pix_s1.alpha == ALPHA_CLEAR);

	always_comb begin
		if (transp) begin
			colour = '0;
		end else begin
			colour = {blend(pix_s1.red,   pix_s1.alpha, bg_q[7:0]),
			          blend(pix_s1.green, pix_s1.alpha, bg_q[15:8]),
			          blend(pix_s1.blue,  pix_s1.alpha, bg_q[23:16])};
		end
	end

	// Mask byte offset: reversed row times the stride in bytes, plus column / 8.
	assign row_base = {5'd0, pix_s1.rev_row} * {8'd0, pix_s1.words};
	assign offset   = {row_base[11:0], 1'b0} + OFFSET_W'(pix_s1.col[7:3]);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			data_s2   <= {pix_s1.col[BITPOS_W-1:0], offset, colour};
			transp_s2 <= transp;
			last_s2   <= pix_s1.last;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = data_s2;
	assign m_tuser  = transp_s2;
	assign m_tlast  = last_s2;

endmodule

@@ hdl/apwm_checker.sv @@
`include "alpha_precompose_with_mask_assert.svh"

module apwm_checker
	import apwm_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic [S_TDATA_W-1:0] s_tdata,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata,
	input logic [M_TUSER_W-1:0] m_tuser,
	input logic                 m_tlast
);

	// A stalled output transfer keeps its content.
	`APWM_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "output changed while stalled")

	// A transparent pixel carries black colour.
	`APWM_ASSERT_SAME(a_transp_black, m_tvalid && m_tuser[0], m_tdata[23:0] == '0, "transparent pixel is not black")

	// With the output flowing, a zero alpha pixel comes out flagged from the output register.
	`APWM_ASSERT_NEXT(a_clear_flagged, s_tvalid && s_tready && s_tdata[31:24] == ALPHA_CLEAR ##1 m_tready, m_tvalid && m_tuser[0], "zero alpha pixel not flagged")

	// An opaque pixel passes its colour through unchanged.
	`APWM_ASSERT_NEXT(a_opaque_pass, s_tvalid && s_tready && s_tdata[31:24] == ALPHA_OPAQUE ##1 m_tready, m_tvalid && !m_tuser[0] && m_tdata[23:0] == $past(s_tdata[23:0], 2), "opaque pixel colour changed")

endmodule

bind alpha_precompose_with_mask apwm_checker u_apwm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

@@ tb/alpha_precompose_with_mask_test.sv @@
`timescale 1ns / 100ps

module alpha_precompose_with_mask_test;
	import apwm_pkg::*;

	// Register index that decodes to nothing; writes to it must be ignored.
	localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int QUIET_LIMIT = 2000;
	localparam int LONG_HOLD   = 120;
	localparam int RANDOM_ITEMS = 1000;

	// One composited pixel as it should leave the block.
	typedef struct {
		logic [7:0]  blue;
		logic [7:0]  green;
		logic [7:0]  red;
		logic        transparent;
		logic [12:0] offset;
		logic [2:0]  bit_pos;
		logic        last;
	} composite_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata = '0;   // blue, green, red, alpha
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;        // blue, green, red, mask_offset, mask_bit_pos
	logic [M_TUSER_W-1:0]  m_tuser;        // transparent
	logic                  m_tlast;        // last_pixel

	// Shadow of the block's registers and raster counters.
	logic [23:0] bg_colour = 24'd0;
	logic [8:0]  frame_width = SIDE_RESET;
	logic [8:0]  frame_height = SIDE_RESET;
	int          col_count = 0;
	int          row_count = 0;

	logic [31:0] source_pixels[$];
	composite_t  expected_pixels[$];
	int          queued_count = 0;
	int          checked_count = 0;
	int          error_count = 0;
	int          frames_done = 0;
	int          transparent_seen = 0;
	int          config_writes = 0;
	int          quiet_cycles = 0;
	int          send_gap = 0;
	int          hold_left = 0;
	bit          burst_mode = 1'b0;
	bit          long_hold_req = 1'b0;
	bit          long_hold_done = 1'b0;

	alpha_precompose_with_mask u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// A size of zero counts as one and anything above the maximum saturates.
	function automatic int side_clamp(input logic [8:0] side);
		if (side == 9'd0)
			return 1;
		if (side > MAX_SIDE)
			return MAX_SIDE;
		return int'(side);
	endfunction

	function automatic logic [7:0] mix_channel(input int src, input int alpha, input int bg);
		return 8'((src * alpha + bg * (255 - alpha) + 127) / 255);
	endfunction

	// Works out the output for one source pixel and advances the raster position.
	function automatic composite_t composite_pixel(input logic [31:0] px);
		int w;
		int h;
		int c;
		int r;
		int stride;
		int alpha;
		composite_t res;
		w = side_clamp(frame_width);
		h = side_clamp(frame_height);
		c = (col_count > w - 1) ? w - 1 : col_count;
		r = (row_count > h - 1) ? h - 1 : row_count;
		alpha = int'(px[31:24]);
		stride = ((w + 15) / 16) * 2;
		res.offset = 13'((h - 1 - r) * stride + c / 8);
		res.bit_pos = 3'(c % 8);
		if (alpha == 0) begin
			res.blue = 8'd0;
			res.green = 8'd0;
			res.red = 8'd0;
			res.transparent = 1'b1;
		end else begin
			res.blue = mix_channel(int'(px[7:0]), alpha, int'(bg_colour[23:16]));
			res.green = mix_channel(int'(px[15:8]), alpha, int'(bg_colour[15:8]));
			res.red = mix_channel(int'(px[23:16]), alpha, int'(bg_colour[7:0]));
			res.transparent = 1'b0;
		end
		res.last = (c == w - 1) && (r == h - 1);
		if (c == w - 1) begin
			col_count = 0;
			row_count = res.last ? 0 : (r + 1) % 256;
		end else begin
			col_count = c + 1;
			row_count = r;
		end
		return res;
	endfunction

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			error_count++;
		end
	endfunction

	// Mostly back-to-back, sometimes a short pause, now and then a long one.
	function automatic int next_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Side value with random bits above the register width.
	function automatic logic [31:0] pick_side(input int usual_max);
		logic [31:0] v;
		v = $urandom;
		case ($urandom_range(0, 19))
			0: v[8:0] = 9'd0;
			1: v[8:0] = 9'(MAX_SIDE);
			2: v[8:0] = 9'($urandom_range(MAX_SIDE + 1, 511));
			default: v[8:0] = 9'($urandom_range(1, usual_max));
		endcase
		return v;
	endfunction

	function automatic logic [31:0] pick_background();
		logic [31:0] v;
		v = $urandom;
		case ($urandom_range(0, 9))
			0: v[23:0] = 24'd0;
			1: v[23:0] = 24'hFF_FFFF;
			default: ;
		endcase
		return v;
	endfunction

	// Pixel words are alpha, red, green, blue from the top byte down.
	task automatic queue_pixel(input logic [31:0] px);
		source_pixels.push_back(px);
		queued_count++;
	endtask

	task automatic queue_random_pixel();
		logic [31:0] px;
		px = $urandom;
		case ($urandom_range(0, 9))
			0, 1: px[31:24] = ALPHA_CLEAR;
			2: px[31:24] = ALPHA_OPAQUE;
			3: px[31:24] = $urandom_range(0, 1) ? 8'd1 : 8'd254;
			default: ;
		endcase
		queue_pixel(px);
	endtask

	// Returns once every queued pixel has come out and the pipeline has drained.
	task automatic wait_idle();
		while (checked_count != queued_count)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Setup cycle, then access cycle; the shadow copy follows once the write lands.
	task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		config_writes++;
		case (idx)
			REG_BACKGROUND: bg_colour = value[23:0];
			REG_WIDTH: begin
				frame_width = value[8:0];
				col_count = 0;
				row_count = 0;
			end
			REG_HEIGHT: begin
				frame_height = value[8:0];
				col_count = 0;
				row_count = 0;
			end
			default: ;
		endcase
	endtask

	// Source side: offers queued pixels, with random gaps after each transfer.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			send_gap = 0;
		end else if (!s_tvalid || s_tready) begin
			if (send_gap > 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (source_pixels.size() > 0) begin
				s_tdata <= source_pixels.pop_front();
				s_tvalid <= 1'b1;
				send_gap = burst_mode ? 0 : next_gap();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Sink side: random back-pressure, plus one long hold when asked for.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_left = 0;
		end else if (long_hold_req && !long_hold_done) begin
			long_hold_done = 1'b1;
			hold_left = LONG_HOLD;
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (burst_mode || $urandom_range(0, 3) != 0) begin
			m_tready <= 1'b1;
		end else begin
			hold_left = next_gap();
			m_tready <= 1'b0;
		end
	end

	// Predicts on every input transfer and checks every output transfer.
	always @(posedge clk) begin
		composite_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				expected_pixels.push_back(composite_pixel(s_tdata));
			if (m_tvalid && m_tready) begin
				if (expected_pixels.size() == 0) begin
					$error("output transfer with nothing expected: m_tdata %h", m_tdata);
					error_count++;
				end else begin
					want = expected_pixels.pop_front();
					check_field("out_blue", int'(want.blue), int'(m_tdata[7:0]));
					check_field("out_green", int'(want.green), int'(m_tdata[15:8]));
					check_field("out_red", int'(want.red), int'(m_tdata[23:16]));
					check_field("mask_offset", int'(want.offset), int'(m_tdata[36:24]));
					check_field("mask_bit_pos", int'(want.bit_pos), int'(m_tdata[39:37]));
					check_field("transparent", int'(want.transparent), int'(m_tuser[0]));
					check_field("last_pixel", int'(want.last), int'(m_tlast));
					checked_count++;
					if (m_tlast)
						frames_done++;
					if (m_tuser[0])
						transparent_seen++;
				end
			end
		end
	end

	// Ends the run if nothing moves on either stream for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Timed out after %0d cycles without a transfer.", quiet_cycles);
			$display("CHECKS FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int phase;
		int w_eff;
		int h_eff;
		int count;
		logic [2:0] which;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: black background, 16 by 16 frame, channel extremes.
		queue_pixel({8'h00, 8'h56, 8'h34, 8'h12});
		queue_pixel({8'hFF, 8'hFF, 8'hFF, 8'hFF});
		queue_pixel({8'hFF, 8'h00, 8'h00, 8'h00});
		queue_pixel({8'h00, 8'hFF, 8'hFF, 8'hFF});
		queue_pixel({8'h00, 8'h00, 8'h00, 8'h00});
		queue_pixel({8'h01, 8'h80, 8'h00, 8'hFF});
		queue_pixel({8'hFE, 8'h7F, 8'hFF, 8'h00});
		queue_pixel({8'h80, 8'h80, 8'h80, 8'h80});
		wait_idle();

		// New background mid-frame: the raster position carries on.
		reg_write(REG_BACKGROUND, 32'hA5FF_FFFF);
		queue_pixel({8'h01, 8'h00, 8'h00, 8'h00});
		queue_pixel({8'h01, 8'hFF, 8'hFF, 8'hFF});
		queue_pixel({8'h7F, 8'h56, 8'h34, 8'h12});
		queue_pixel({8'h00, 8'h00, 8'h00, 8'h00});
		wait_idle();
		reg_write(REG_BACKGROUND, 32'h00C0_8040);
		queue_pixel({8'h80, 8'h00, 8'h00, 8'h00});
		queue_pixel({8'h80, 8'hFF, 8'hFF, 8'hFF});
		wait_idle();

		// A write to an unmapped address changes nothing.
		reg_write(REG_UNUSED, 32'hFFFF_FFFF);
		queue_pixel({8'hC0, 8'h60, 8'h40, 8'h20});
		wait_idle();

		// Zero sizes read as a one-pixel frame, so every pixel is the last.
		reg_write(REG_WIDTH, 32'h0000_0000);
		reg_write(REG_HEIGHT, 32'hFFFF_FE00);
		queue_pixel({8'hFF, 8'hC0, 8'hB0, 8'hA0});
		queue_pixel({8'h00, 8'h03, 8'h02, 8'h01});
		queue_pixel({8'hA5, 8'h5A, 8'hAA, 8'h55});
		wait_idle();

		// Oversized values saturate to the largest frame and widest mask stride.
		reg_write(REG_WIDTH, 32'h0000_01FF);
		reg_write(REG_HEIGHT, 32'h0000_012C);
		repeat (6) queue_random_pixel();
		wait_idle();

		// Random phases: new settings while idle, then whole and partial frames.
		phase = 0;
		while (queued_count < RANDOM_ITEMS + 24) begin
			phase++;
			wait_idle();
			which = 3'($urandom_range(1, 7));
			if (which[0])
				reg_write(REG_BACKGROUND, pick_background());
			if (which[1])
				reg_write(REG_WIDTH, pick_side(24));
			if (which[2])
				reg_write(REG_HEIGHT, pick_side(6));
			if ($urandom_range(0, 9) == 0)
				reg_write(REG_UNUSED, $urandom);
			w_eff = side_clamp(frame_width);
			h_eff = side_clamp(frame_height);
			if (w_eff * h_eff <= 60)
				count = w_eff * h_eff * $urandom_range(1, 3) + $urandom_range(0, 4);
			else if (w_eff * h_eff <= 300)
				count = w_eff * h_eff + $urandom_range(0, 4);
			else
				count = $urandom_range(10, 60);
			burst_mode = ($urandom_range(0, 3) == 0);
			// One phase holds the sink off long enough to back up the input.
			if (phase == 3) begin
				burst_mode = 1'b0;
				long_hold_req = 1'b1;
				if (count < 80)
					count = 80;
			end
			repeat (count) queue_random_pixel();
		end

		wait_idle();
		repeat (10) @(posedge clk);
		if (expected_pixels.size() != 0) begin
			$error("%0d expected pixels never came out", expected_pixels.size());
			error_count++;
		end
		$display("Checked %0d pixels over %0d register writes; %0d frames ended, %0d transparent.",
			checked_count, config_writes, frames_done, transparent_seen);
		$display("Settings ranged from a single pixel to the saturated 256 by 256 frame.");
		if (error_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
